### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define VLR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed: label");
// Checked on every rising clock edge, reset included.
`define VLR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed: label");
`else
`define VLR_ASSERT(label, prop)
`define VLR_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/vlr_pkg.sv
package vlr_pkg;

   // Pipeline depths of the iterative units, one result bit per stage.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;

   // Operation codes.
   localparam logic [1:0] OP_NORMALIZE = 2'd0;
   localparam logic [1:0] OP_SET_LEN   = 2'd1;
   localparam logic [1:0] OP_LIMIT_LEN = 2'd2;
   localparam logic [1:0] OP_LEN_ONLY  = 2'd3;

   // Unit length in Q16.16.
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // One input word with the operation code, the components and the target length.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] vec_x;
      logic [31:0] vec_y;
      logic [31:0] vec_z;
      logic [31:0] target_len;
   } item_type;

   // Word state between the length stage and the output stage.
   typedef struct packed {
      logic [31:0] vec_x;
      logic [31:0] vec_y;
      logic [31:0] vec_z;
      logic [31:0] length;
      logic        doit;
      logic        fneg;
   } post_type;

   // Magnitude of a two's complement word; the most negative value maps to 2^31.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // Signs and saturates a quotient. Bit 32 of the result is the clip flag.
   function automatic logic [32:0] sat_comp(input logic neg, input logic [31:0] q,
                                            input logic ovf);
      logic [32:0] res;
      res = 33'd0;
      if (q == 32'd0 && !ovf) begin
         res = 33'd0;
      end else if (!neg) begin
         if (ovf || q > 32'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
         else res = {1'b0, q};
      end else begin
         if (ovf || q > 32'h8000_0000) res = {1'b1, 32'h8000_0000};
         else res = {1'b0, 32'd0 - q};
      end
      return res;
   endfunction

endpackage

### rtl/vector_length_rescale.sv
// Vector length rescale.
// The req channel takes one signed Q16.16 3D vector, a target length and an
// operation code per word: normalize, set length, limit length or length only.
// The rsp channel returns the resulting vector, its Euclidean length and the
// rescaled and saturated flags, one word for each request word, in order.
// From an accepted request to rsp_tvalid, magnitudes, squares and their sum
// take three stages, the square root 32 stages, the scale products one stage,
// the divide 32 stages and the output register one. Throughput is one word
// per cycle unless the pipeline is frozen; the root and divide pipelines
// retire one result bit per stage, so each stage holds a different word.
// Reset clears every valid bit; no word is in flight after it.
// When the receiver holds rsp_tready low with a word waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is lost
// or repeated, and the flow resumes at full rate once rsp_tready rises.
// A zero-length vector always passes unchanged.
`include "assert_macros.svh"
module vector_length_rescale import vlr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x [31:0], vec_y [63:32], vec_z [95:64], target_len [127:96]
   input  logic [127:0] req_tdata,
   // op [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64], length [127:96]
   output logic [127:0] rsp_tdata,
   // rescaled [0], saturated [1]
   output logic [1:0]   rsp_tuser
);

   logic en;

   // Stage 1: input word and component magnitudes.
   logic        s1_valid_ff;
   item_type    s1_item_ff;
   logic [31:0] s1_mag_ff [3];

   // Stage 2: squares.
   logic        s2_valid_ff;
   item_type    s2_item_ff;
   logic [63:0] s2_sq_ff [3];

   // Stage 3: sum of squares.
   logic        s3_valid_ff;
   item_type    s3_item_ff;
   logic [63:0] s3_sum_ff;

   // Word delay line beside the root pipeline.
   logic        sq_valid_ff [SQRT_STEPS];
   item_type    sq_item_ff  [SQRT_STEPS];
   logic [31:0] root;

   // Stage 4: scale products and the decision.
   logic        s4_valid_ff;
   post_type    s4_post_ff;
   logic [63:0] s4_num_ff [3];
   post_type    s4_post_in;
   logic [31:0] fmag;

   // Word delay line beside the divide lanes.
   logic        dv_valid_ff [DIV_STEPS];
   post_type    dv_post_ff  [DIV_STEPS];
   logic [31:0] quot [3];
   logic        ovf  [3];

   // Output register.
   logic         rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;
   logic [127:0] rsp_data_in;
   logic [1:0]   rsp_user_in;

   item_type req_item;
   post_type last_post;

   // The pipeline advances unless a finished word is blocked.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign req_item.op         = req_tuser;
   assign req_item.vec_x      = req_tdata[31:0];
   assign req_item.vec_y      = req_tdata[63:32];
   assign req_item.vec_z      = req_tdata[95:64];
   assign req_item.target_len = req_tdata[127:96];

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= sq_valid_ff[SQRT_STEPS-1];
      end
   end

   // Front stages: magnitudes, squares, sum.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff   <= req_item;
         s1_mag_ff[0] <= mag32(req_item.vec_x);
         s1_mag_ff[1] <= mag32(req_item.vec_y);
         s1_mag_ff[2] <= mag32(req_item.vec_z);
         s2_item_ff   <= s1_item_ff;
         s2_sq_ff[0]  <= s1_mag_ff[0] * s1_mag_ff[0];
         s2_sq_ff[1]  <= s1_mag_ff[1] * s1_mag_ff[1];
         s2_sq_ff[2]  <= s1_mag_ff[2] * s1_mag_ff[2];
         s3_item_ff   <= s2_item_ff;
         s3_sum_ff    <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      end
   end

   vlr_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .val   (s3_sum_ff),
      .root  (root)
   );

   // Carry each word alongside its root.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq_line
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k] <= (k == 0) ? s3_valid_ff : sq_valid_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_item_ff[k] <= (k == 0) ? s3_item_ff : sq_item_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // Pick the scale factor and decide whether the vector is scaled.
   always_comb begin
      item_type it;
      it = sq_item_ff[SQRT_STEPS-1];
      s4_post_in.vec_x  = it.vec_x;
      s4_post_in.vec_y  = it.vec_y;
      s4_post_in.vec_z  = it.vec_z;
      s4_post_in.length = root;
      s4_post_in.doit   = 1'b0;
      s4_post_in.fneg   = 1'b0;
      fmag              = mag32(it.target_len);
      if (root != 32'd0) begin
         unique case (it.op)
            OP_NORMALIZE: begin
               s4_post_in.doit = 1'b1;
               fmag            = ONE_Q16;
            end
            OP_SET_LEN: begin
               s4_post_in.doit = 1'b1;
               s4_post_in.fneg = it.target_len[31];
            end
            OP_LIMIT_LEN: begin
               s4_post_in.doit = ($signed({1'b0, root}) >
                                  $signed({it.target_len[31], it.target_len}));
               s4_post_in.fneg = it.target_len[31];
            end
            OP_LEN_ONLY: begin
               s4_post_in.doit = 1'b0;
            end
            default: begin
               s4_post_in.doit = 1'b0;
            end
         endcase
      end
   end

   // Stage 4: component magnitude times factor magnitude.
   always_ff @(posedge clock) begin
      if (en) begin
         s4_post_ff   <= s4_post_in;
         s4_num_ff[0] <= mag32(s4_post_in.vec_x) * fmag;
         s4_num_ff[1] <= mag32(s4_post_in.vec_y) * fmag;
         s4_num_ff[2] <= mag32(s4_post_in.vec_z) * fmag;
      end
   end

   // One divide lane per component, all divided by the length.
   for (genvar c = 0; c < 3; c++) begin : g_lane
      vlr_div_lane u_div (
         .clock (clock),
         .en    (en),
         .num   (s4_num_ff[c]),
         .den   (s4_post_ff.length),
         .quot  (quot[c]),
         .ovf   (ovf[c])
      );
   end

   // Carry each word alongside its quotients.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv_line
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k] <= (k == 0) ? s4_valid_ff : dv_valid_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_post_ff[k] <= (k == 0) ? s4_post_ff : dv_post_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign last_post = dv_post_ff[DIV_STEPS-1];

   // Sign, saturate or pass the vector through.
   always_comb begin
      logic [32:0] rx;
      logic [32:0] ry;
      logic [32:0] rz;
      rx = sat_comp(last_post.vec_x[31] ^ last_post.fneg, quot[0], ovf[0]);
      ry = sat_comp(last_post.vec_y[31] ^ last_post.fneg, quot[1], ovf[1]);
      rz = sat_comp(last_post.vec_z[31] ^ last_post.fneg, quot[2], ovf[2]);
      if (last_post.doit) begin
         rsp_data_in = {last_post.length, rz[31:0], ry[31:0], rx[31:0]};
         rsp_user_in = {rx[32] | ry[32] | rz[32], 1'b1};
      end else begin
         rsp_data_in = {last_post.length, last_post.vec_z, last_post.vec_y,
                        last_post.vec_x};
         rsp_user_in = 2'b00;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks on the pipeline control and the result flags.
   `VLR_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_tvalid)
   `VLR_ASSERT(a_ready_follows_stall, req_tready == (!rsp_tvalid || rsp_tready))
   `VLR_ASSERT(a_sat_needs_scale, (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
   `VLR_ASSERT(a_zero_len_passes, (rsp_tvalid && rsp_tdata[127:96] == 32'd0) |-> !rsp_tuser[0])

endmodule

### rtl/vlr_isqrt.sv
// Floor square root of a 64-bit value, one root bit per pipeline stage.
module vlr_isqrt import vlr_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] val,
   output logic [31:0] root
);

   logic [32:0] rem_ff  [SQRT_STEPS];
   logic [31:0] root_ff [SQRT_STEPS];
   logic [63:0] val_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [32:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] val_prev;
      logic [34:0] t;
      logic [34:0] trial;
      logic [34:0] diff;
      logic        ge;
      logic [32:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev  = 33'd0;
         assign root_prev = 32'd0;
         assign val_prev  = val;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign val_prev  = val_ff[k-1];
      end

      // Bring down the next bit pair and try a one digit.
      assign t      = {rem_prev, val_prev[63:62]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign ge     = (t >= trial);
      assign diff   = t - trial;
      assign rem_in = ge ? diff[32:0] : t[32:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_prev[30:0], ge};
            val_ff[k]  <= {val_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

### rtl/vlr_div_lane.sv
// Pipelined 64 by 32 bit unsigned divide, one quotient bit per stage.
// Quotients of 2^32 or more only raise ovf.
module vlr_div_lane import vlr_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic [31:0] quot,
   output logic        ovf
);

   logic [31:0] rem_ff [DIV_STEPS];
   logic [31:0] lo_ff  [DIV_STEPS];
   logic [31:0] q_ff   [DIV_STEPS];
   logic [31:0] den_ff [DIV_STEPS];
   logic        ovf_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [31:0] rem_prev;
      logic [31:0] lo_prev;
      logic [31:0] q_prev;
      logic [31:0] den_prev;
      logic        ovf_prev;
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;
      logic [31:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = num[63:32];
         assign lo_prev  = num[31:0];
         assign q_prev   = 32'd0;
         assign den_prev = den;
         assign ovf_prev = (num[63:32] >= den);
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
      end

      // Shift in the next numerator bit and subtract when it fits.
      assign t      = {rem_prev, lo_prev[31]};
      assign ge     = (t >= {1'b0, den_prev});
      assign diff   = t - {1'b0, den_prev};
      assign rem_in = ge ? diff[31:0] : t[31:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= {lo_prev[30:0], 1'b0};
            q_ff[k]   <= {q_prev[30:0], ge};
            den_ff[k] <= den_prev;
            ovf_ff[k] <= ovf_prev;
         end
      end
   end

   assign quot = q_ff[DIV_STEPS-1];
   assign ovf  = ovf_ff[DIV_STEPS-1];

endmodule
